@@ rtl/core/lattice_hop_excitation_generator_unit_macros.svh @@
// Assertion macros for the hop excitation generator.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef LATTICE_HOP_EXCITATION_GENERATOR_UNIT_MACROS_SVH
`define LATTICE_HOP_EXCITATION_GENERATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LHG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lhg assertion failed");
`define LHG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lhg assertion failed");
`else
`define LHG_ASSERT(lbl, clk, rst, prop)
`define LHG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/lhg_pkg.sv @@
// Shared types and constants of the hop excitation generator.
// No dependencies; used by every module of the block.
package lhg_pkg;

   localparam int OCC_W            = 32;
   localparam int ORB_W            = 5;
   localparam int RAND_W           = 16;
   localparam int RING_W           = 6;
   localparam int CNT_W            = 7;
   localparam int DEF_MAX_ORBITALS = 32;
   localparam int DEF_RANDOM_BITS  = 16;
   localparam int RING_MIN         = 4;
   localparam int TASK_Q_DEPTH     = 2;
   localparam logic [RING_W-1:0] RING_RESET = 6'd32;

   typedef enum logic {
      CMD_ENUMERATE = 1'b0,
      CMD_PICK      = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      DIR_LEFT  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_NONE  = 2'd2
   } direction_type;

   typedef struct packed {
      command_type        command;
      logic [OCC_W-1:0]   occupation;
      logic [RAND_W-1:0]  random_value;
   } req_type;

   typedef struct packed {
      logic [OCC_W-1:0]   target_state;
      logic [ORB_W-1:0]   from_orbital;
      logic [ORB_W-1:0]   to_orbital;
      direction_type      direction;
      logic [CNT_W-1:0]   choice_count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic               pick;
      logic               source_only;
      logic [OCC_W-1:0]   occupation;
      logic [OCC_W-1:0]   left_mask;
      logic [OCC_W-1:0]   right_mask;
      logic [RING_W-1:0]  ring_size;
      logic [CNT_W-1:0]   choice_count;
      logic [CNT_W-1:0]   skip;
   } hop_task_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_COUNT,
      FR_PICK
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SKIP,
      BK_EMIT
   } back_state_type;

endpackage

@@ rtl/core/lhg_front.sv @@
// Front end: accepts requests, builds hop candidate masks, counts and picks.
// Depends on lhg_pkg; feeds lhg_task_queue.
module lhg_front #(
   parameter int MAX_ORBITALS = lhg_pkg::DEF_MAX_ORBITALS,
   parameter int RANDOM_BITS  = lhg_pkg::DEF_RANDOM_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  lhg_pkg::req_type            req_data,
   input  logic [lhg_pkg::RING_W-1:0]  ring_size,
   output logic                        task_push,
   input  logic                        task_full,
   output lhg_pkg::hop_task_type       task_data
);
   import lhg_pkg::*;

   localparam int RAND_USE = (RANDOM_BITS < RAND_W) ? RANDOM_BITS : RAND_W;
   localparam int PROD_W   = RANDOM_BITS + CNT_W;

   front_state_type     state_ff, state_in;
   logic                pick_ff, pick_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;
   logic [RAND_W-1:0]   rnd_ff, rnd_in;
   logic [RING_W-1:0]   ring_ff, ring_in;
   logic [OCC_W-1:0]    lmask_ff, lmask_in;
   logic [OCC_W-1:0]    rmask_ff, rmask_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic [OCC_W-1:0]    lmask_new, rmask_new;
   logic [CNT_W-1:0]    hop_count;
   logic [RANDOM_BITS-1:0] r_eff;
   logic [PROD_W-1:0]   product;
   logic [CNT_W-1:0]    pick_idx;
   logic                source_only;

   // candidate masks for the incoming request
   always_comb begin
      logic [ORB_W-1:0] ltgt, rtgt;
      logic             in_ring;
      lmask_new = '0;
      rmask_new = '0;
      for (int i = 0; i < MAX_ORBITALS; i++) begin
         in_ring = RING_W'(i) < ring_size;
         if (i >= 2) begin
            ltgt = ORB_W'(i - 2);
         end else begin
            ltgt = ORB_W'(RING_W'(i) + ring_size - RING_W'(2));
         end
         if (RING_W'(i) + RING_W'(2) < ring_size) begin
            rtgt = ORB_W'(i + 2);
         end else begin
            rtgt = ORB_W'(RING_W'(i) + RING_W'(2) - ring_size);
         end
         lmask_new[i] = in_ring && req_data.occupation[i] && !req_data.occupation[ltgt];
         rmask_new[i] = in_ring && req_data.occupation[i] && !req_data.occupation[rtgt];
      end
   end

   assign hop_count   = CNT_W'($countones(lmask_ff)) + CNT_W'($countones(rmask_ff));

   assign r_eff       = RANDOM_BITS'(rnd_ff[RAND_USE-1:0]);
   assign product     = PROD_W'(r_eff) * PROD_W'(cnt_ff + CNT_W'(1));
   assign pick_idx    = product[PROD_W-1:RANDOM_BITS];
   assign source_only = pick_ff ? (pick_idx >= cnt_ff) : (cnt_ff == '0);

   assign full = (state_ff != FR_IDLE);

   always_comb begin
      task_data.pick         = pick_ff;
      task_data.source_only  = source_only;
      task_data.occupation   = occ_ff;
      task_data.left_mask    = lmask_ff;
      task_data.right_mask   = rmask_ff;
      task_data.ring_size    = ring_ff;
      task_data.choice_count = cnt_ff + CNT_W'(1);
      task_data.skip         = (pick_ff && !source_only) ? pick_idx : '0;
   end

   always_comb begin
      state_in  = state_ff;
      pick_in   = pick_ff;
      occ_in    = occ_ff;
      rnd_in    = rnd_ff;
      ring_in   = ring_ff;
      lmask_in  = lmask_ff;
      rmask_in  = rmask_ff;
      cnt_in    = cnt_ff;
      task_push = 1'b0;
      unique case (state_ff)
         FR_IDLE: begin
            if (push) begin
               pick_in  = (req_data.command == CMD_PICK);
               occ_in   = req_data.occupation;
               rnd_in   = req_data.random_value;
               ring_in  = ring_size;
               lmask_in = lmask_new;
               rmask_in = rmask_new;
               state_in = FR_COUNT;
            end
         end
         FR_COUNT: begin
            cnt_in   = hop_count;
            state_in = FR_PICK;
         end
         FR_PICK: begin
            if (!task_full) begin
               task_push = 1'b1;
               state_in  = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff  <= pick_in;
      occ_ff   <= occ_in;
      rnd_ff   <= rnd_in;
      ring_ff  <= ring_in;
      lmask_ff <= lmask_in;
      rmask_ff <= rmask_in;
      cnt_ff   <= cnt_in;
   end

endmodule

@@ rtl/core/lhg_task_queue.sv @@
// Short task queue between the front and back ends.
// Depends on lhg_pkg and the assertion macro header.
`include "lattice_hop_excitation_generator_unit_macros.svh"
module lhg_task_queue #(
   parameter int DEPTH = lhg_pkg::TASK_Q_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  lhg_pkg::hop_task_type  push_data,
   input  logic                   pop,
   output logic                   empty,
   output lhg_pkg::hop_task_type  pop_data
);
   import lhg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   hop_task_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_QW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `LHG_ASSERT(a_no_overrun, clock, reset, !(push && full))
   `LHG_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_QW'(DEPTH))
   `LHG_ASSERT(a_empty_ptrs, clock, reset, (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))

endmodule

@@ rtl/core/lhg_back.sv @@
// Back end: walks the candidate masks of one task and emits results.
// Depends on lhg_pkg and the assertion macro header; owns the result register.
`include "lattice_hop_excitation_generator_unit_macros.svh"
module lhg_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   task_empty,
   output logic                   task_pop,
   input  lhg_pkg::hop_task_type  task_data,
   output logic                   empty,
   input  logic                   pop,
   output lhg_pkg::rsp_type       rsp_data
);
   import lhg_pkg::*;

   function automatic logic [ORB_W-1:0] lowest_index(input logic [OCC_W-1:0] m);
      logic [ORB_W-1:0] idx;
      idx = '0;
      for (int k = OCC_W - 1; k >= 0; k--) begin
         if (m[k]) begin
            idx = ORB_W'(k);
         end
      end
      return idx;
   endfunction

   back_state_type      state_ff, state_in;
   hop_task_type        cur_ff, cur_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                is_left;
   logic [OCC_W-1:0]    sel_mask;
   logic [ORB_W-1:0]    from_idx, to_idx;
   logic [RING_W-1:0]   from_ext;
   logic [OCC_W-1:0]    lmask_next, rmask_next;
   logic [OCC_W-1:0]    hop_state;
   logic                out_free;

   assign is_left  = (cur_ff.left_mask != '0);
   assign sel_mask = is_left ? cur_ff.left_mask : cur_ff.right_mask;
   assign from_idx = lowest_index(sel_mask);
   assign from_ext = RING_W'(from_idx);

   always_comb begin
      if (is_left) begin
         if (from_ext >= RING_W'(2)) begin
            to_idx = ORB_W'(from_ext - RING_W'(2));
         end else begin
            to_idx = ORB_W'(from_ext + cur_ff.ring_size - RING_W'(2));
         end
      end else begin
         if (from_ext + RING_W'(2) < cur_ff.ring_size) begin
            to_idx = ORB_W'(from_ext + RING_W'(2));
         end else begin
            to_idx = ORB_W'(from_ext + RING_W'(2) - cur_ff.ring_size);
         end
      end
   end

   assign lmask_next = is_left ? (cur_ff.left_mask & (cur_ff.left_mask - OCC_W'(1)))
                               : cur_ff.left_mask;
   assign rmask_next = is_left ? cur_ff.right_mask
                               : (cur_ff.right_mask & (cur_ff.right_mask - OCC_W'(1)));
   assign hop_state  = (cur_ff.occupation & ~(OCC_W'(1) << from_idx)) | (OCC_W'(1) << to_idx);

   assign out_free = !out_valid_ff || pop;
   assign empty    = !out_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      rsp_in       = rsp_ff;
      out_valid_in = out_valid_ff && !pop;
      task_pop     = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!task_empty) begin
               task_pop = 1'b1;
               cur_in   = task_data;
               if (!task_data.source_only && task_data.skip != '0) begin
                  state_in = BK_SKIP;
               end else begin
                  state_in = BK_EMIT;
               end
            end
         end
         BK_SKIP: begin
            cur_in.left_mask  = lmask_next;
            cur_in.right_mask = rmask_next;
            cur_in.skip       = cur_ff.skip - CNT_W'(1);
            if (cur_ff.skip == CNT_W'(1)) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               out_valid_in        = 1'b1;
               rsp_in.choice_count = cur_ff.choice_count;
               if (cur_ff.source_only) begin
                  rsp_in.target_state = cur_ff.occupation;
                  rsp_in.from_orbital = '0;
                  rsp_in.to_orbital   = '0;
                  rsp_in.direction    = DIR_NONE;
                  rsp_in.last         = 1'b1;
                  state_in            = BK_IDLE;
               end else begin
                  rsp_in.target_state = hop_state;
                  rsp_in.from_orbital = from_idx;
                  rsp_in.to_orbital   = to_idx;
                  rsp_in.direction    = is_left ? DIR_LEFT : DIR_RIGHT;
                  rsp_in.last         = cur_ff.pick || ((lmask_next | rmask_next) == '0);
                  cur_in.left_mask    = lmask_next;
                  cur_in.right_mask   = rmask_next;
                  if (rsp_in.last) begin
                     state_in = BK_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   `LHG_ASSERT(a_skip_has_hop, clock, reset, (state_ff == BK_SKIP) |-> ((cur_ff.left_mask | cur_ff.right_mask) != '0))
   `LHG_ASSERT(a_hop_moves, clock, reset, (out_valid_ff && rsp_ff.direction != DIR_NONE) |-> (rsp_ff.from_orbital != rsp_ff.to_orbital))
   `LHG_ASSERT_NEXT(a_pop_loads, clock, reset, task_pop, state_ff != BK_IDLE)

endmodule

@@ rtl/core/lattice_hop_excitation_generator_unit.sv @@
// Path: the front registers a request, counts its hops and, in pick mode, picks one, then
// pushes a task; the back loads it, steps through the skip state in pick mode, then emits.
// The front takes no new request until it has pushed its task. The back loads a task, then
// emits one result per cycle in enumerate mode while the result register is free, or skips
// and emits one result in pick mode. The slower side and result stalls set the rate.
// Reset is synchronous: ring size returns to 32, queue and result register empty.
module lattice_hop_excitation_generator_unit #(
   parameter int MAX_ORBITALS = lhg_pkg::DEF_MAX_ORBITALS,
   parameter int RANDOM_BITS  = lhg_pkg::DEF_RANDOM_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  lhg_pkg::req_type            req_data,
   output logic                        empty,
   input  logic                        pop,
   output lhg_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lhg_pkg::RING_W-1:0]  csr_data
);
   import lhg_pkg::*;

   logic [RING_W-1:0]   ring_raw_ff, ring_raw_in;
   logic [RING_W-1:0]   ring_size;
   logic                task_push, task_full, task_pop, task_empty;
   hop_task_type        task_in_data, task_out_data;

   assign csr_ready   = 1'b1;
   assign ring_raw_in = (csr_valid && csr_ready) ? csr_data : ring_raw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_raw_ff <= RING_RESET;
      end else begin
         ring_raw_ff <= ring_raw_in;
      end
   end

   always_comb begin
      priority if (ring_raw_ff < RING_W'(RING_MIN)) begin
         ring_size = RING_W'(RING_MIN);
      end else if (ring_raw_ff > RING_W'(MAX_ORBITALS)) begin
         ring_size = RING_W'(MAX_ORBITALS);
      end else begin
         ring_size = ring_raw_ff;
      end
   end

   lhg_front #(
      .MAX_ORBITALS (MAX_ORBITALS),
      .RANDOM_BITS  (RANDOM_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .ring_size (ring_size),
      .task_push (task_push),
      .task_full (task_full),
      .task_data (task_in_data)
   );

   lhg_task_queue #(
      .DEPTH (TASK_Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (task_push),
      .full      (task_full),
      .push_data (task_in_data),
      .pop       (task_pop),
      .empty     (task_empty),
      .pop_data  (task_out_data)
   );

   lhg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .task_empty (task_empty),
      .task_pop   (task_pop),
      .task_data  (task_out_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

@@ tb/lattice_hop_excitation_generator_unit_tb.sv @@
// Self-checking testbench for lattice_hop_excitation_generator_unit: a directed table and
// random requests over several ring sizes, checked against a local hop predictor.
// Depends on lhg_pkg and the unit under test; randomly idles both queue sides.
`timescale 1ns / 100ps

module lattice_hop_excitation_generator_unit_tb;
   import lhg_pkg::*;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int MAX_GAP       = 18;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AFTER    = 120;
   localparam int ITEMS_PER_SET = 37;
   localparam int RANDOM_SETS   = 9;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [RING_W-1:0] ring;
      req_type           req;
      logic              known;
      rsp_type           typed;
   } vector_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              push      = 1'b0;
   logic              full;
   req_type           req_data  = '0;
   logic              empty;
   logic              pop       = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [RING_W-1:0] csr_data  = '0;

   logic              idle_free = 1'b0;
   logic              hold_pop  = 1'b0;
   logic [RING_W-1:0] ring_setting = RING_RESET;
   rsp_type           pending_hops[$];
   vector_type        directed_rows[$];
   int                fail_count     = 0;
   int                cycle_count    = 0;
   int                accepted_count = 0;
   int                pop_gap        = 0;

   lattice_hop_excitation_generator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 149) == 0) begin
         idle_free <= ~idle_free;
      end
   end

   function automatic int draw_gap();
      return idle_free ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic void append_hop(input rsp_type h);
      pending_hops = {pending_hops, h};
   endfunction

   // Hop number p in emission order: left hops by ascending source, then right hops.
   function automatic rsp_type nth_hop(logic [OCC_W-1:0] src, int d, int p);
      rsp_type h;
      int      seen;
      int      pass;
      int      i;
      int      t;
      h = '0;
      seen = 0;
      for (pass = 0; pass < 2; pass++) begin
         for (i = 0; i < d; i++) begin
            t = (pass == 0) ? (i + d - 2) % d : (i + 2) % d;
            if (src[i] && !src[t]) begin
               if (seen == p) begin
                  h.target_state = (src & ~(32'd1 << i)) | (32'd1 << t);
                  h.from_orbital = i[ORB_W-1:0];
                  h.to_orbital   = t[ORB_W-1:0];
                  h.direction    = (pass == 0) ? DIR_LEFT : DIR_RIGHT;
               end
               seen++;
            end
         end
      end
      return h;
   endfunction

   task automatic predict_hops(input req_type req);
      rsp_type h;
      int      d;
      int      n;
      int      p;
      int      i;
      d = (ring_setting < RING_MIN) ? RING_MIN :
          (ring_setting > DEF_MAX_ORBITALS) ? DEF_MAX_ORBITALS : int'(ring_setting);
      n = 0;
      for (i = 0; i < d; i++) begin
         if (req.occupation[i]) begin
            if (!req.occupation[(i + 2) % d]) n++;
            if (!req.occupation[(i + d - 2) % d]) n++;
         end
      end
      if (req.command == CMD_ENUMERATE && n > 0) begin
         for (i = 0; i < n; i++) begin
            h = nth_hop(req.occupation, d, i);
            h.choice_count = CNT_W'(n + 1);
            h.last = (i == n - 1);
            append_hop(h);
         end
      end else begin
         p = (int'(req.random_value) * (n + 1)) >> DEF_RANDOM_BITS;
         if (req.command == CMD_ENUMERATE || p >= n) begin
            h = '0;
            h.target_state = req.occupation;
            h.direction = DIR_NONE;
         end else begin
            h = nth_hop(req.occupation, d, p);
         end
         h.choice_count = CNT_W'(n + 1);
         h.last = 1'b1;
         append_hop(h);
      end
   endtask

   task automatic check_hop(input rsp_type got);
      rsp_type want;
      if (pending_hops.size() == 0) begin
         if (fail_count < MAX_REPORTS) begin
            $display("unexpected response %h", got);
         end
         fail_count++;
         return;
      end
      want = pending_hops.pop_front();
      if (got.target_state !== want.target_state || got.from_orbital !== want.from_orbital ||
          got.to_orbital !== want.to_orbital || got.direction !== want.direction ||
          got.choice_count !== want.choice_count || got.last !== want.last) begin
         if (fail_count < MAX_REPORTS) begin
            $display("mismatch: state/from/to/dir/count/last expected %h/%0d/%0d/%0d/%0d/%0d",
                     want.target_state, want.from_orbital, want.to_orbital, want.direction,
                     want.choice_count, want.last);
            $display("                                        actual %h/%0d/%0d/%0d/%0d/%0d",
                     got.target_state, got.from_orbital, got.to_orbital, got.direction,
                     got.choice_count, got.last);
         end
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            check_hop(rsp_data);
            pop_gap = draw_gap();
         end
         if (hold_pop || pop_gap > 0) begin
            pop <= 1'b0;
            if (!hold_pop) pop_gap = pop_gap - 1;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Long receiver stall so the request side backs up and full asserts.
   initial begin
      wait (accepted_count >= HOLD_AFTER);
      @(posedge clock);
      hold_pop <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_pop <= 1'b0;
   end

   task automatic send_request(input req_type req, input logic known, input rsp_type typed);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (full) @(posedge clock);
      if (known) append_hop(typed);
      else predict_hops(req);
      accepted_count++;
   endtask

   task automatic write_ring(input logic [RING_W-1:0] value);
      push <= 1'b0;
      while (pending_hops.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      ring_setting = value;
   endtask

   task automatic add_row(input logic [RING_W-1:0] ring, input command_type cmd,
                          input logic [OCC_W-1:0] occ, input logic [RAND_W-1:0] rnd,
                          input logic known, input logic [OCC_W-1:0] tgt,
                          input logic [ORB_W-1:0] from_orb, input logic [ORB_W-1:0] to_orb,
                          input direction_type dir, input logic [CNT_W-1:0] cnt);
      vector_type v;
      v.ring = ring;
      v.req.command = cmd;
      v.req.occupation = occ;
      v.req.random_value = rnd;
      v.known = known;
      v.typed.target_state = tgt;
      v.typed.from_orbital = from_orb;
      v.typed.to_orbital = to_orb;
      v.typed.direction = dir;
      v.typed.choice_count = cnt;
      v.typed.last = 1'b1;
      directed_rows = {directed_rows, v};
   endtask

   function automatic req_type random_request();
      req_type r;
      r.command = $urandom_range(0, 1) ? CMD_PICK : CMD_ENUMERATE;
      case ($urandom_range(0, 4))
         0: r.occupation = $urandom();
         1: r.occupation = $urandom() & $urandom() & $urandom();
         2: r.occupation = $urandom() | $urandom();
         3: r.occupation = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
         default: r.occupation = $urandom() & $urandom();
      endcase
      case ($urandom_range(0, 7))
         0: r.random_value = '0;
         1: r.random_value = '1;
         default: r.random_value = RAND_W'($urandom());
      endcase
      return r;
   endfunction

   initial begin
      logic [RING_W-1:0] ring_plan [0:6];
      int                k;
      int                s;
      ring_plan = '{6'd4, 6'd63, 6'd1, 6'd7, 6'd32, 6'd12, 6'd31};

      //       ring   command        occupation    random    known  target  from to  dir  count
      add_row(6'd32, CMD_ENUMERATE, 32'h00000000, 16'h0000, 1'b1, 32'h00000000, 0, 0, DIR_NONE, 1);
      add_row(6'd32, CMD_ENUMERATE, 32'hFFFFFFFF, 16'h0000, 1'b1, 32'hFFFFFFFF, 0, 0, DIR_NONE, 1);
      add_row(6'd32, CMD_PICK,      32'hFFFFFFFF, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 0, 0, DIR_NONE, 1);
      add_row(6'd32, CMD_ENUMERATE, 32'h00000001, 16'h0000, 1'b0, '0, 0, 0, DIR_LEFT, 0);
      add_row(6'd32, CMD_PICK,      32'h00000001, 16'h0000, 1'b1, 32'h40000000, 0, 30, DIR_LEFT, 3);
      add_row(6'd32, CMD_PICK,      32'h00000001, 16'hFFFF, 1'b1, 32'h00000001, 0, 0, DIR_NONE, 3);
      add_row(6'd32, CMD_PICK,      32'h00000001, 16'h8000, 1'b1, 32'h00000004, 0, 2, DIR_RIGHT, 3);
      add_row(6'd32, CMD_ENUMERATE, 32'h55555555, 16'h0000, 1'b1, 32'h55555555, 0, 0, DIR_NONE, 1);
      add_row(6'd32, CMD_ENUMERATE, 32'h11111111, 16'hFFFF, 1'b0, '0, 0, 0, DIR_LEFT, 0);
      add_row(6'd32, CMD_ENUMERATE, 32'h33333333, 16'h0000, 1'b0, '0, 0, 0, DIR_LEFT, 0);
      add_row(6'd32, CMD_ENUMERATE, 32'hAAAAAAAA, 16'h5555, 1'b1, 32'hAAAAAAAA, 0, 0, DIR_NONE, 1);
      add_row(6'd32, CMD_PICK,      32'h80000000, 16'h0000, 1'b1, 32'h20000000, 31, 29, DIR_LEFT, 3);
      add_row(6'd32, CMD_PICK,      32'h80000000, 16'hAAAA, 1'b0, '0, 0, 0, DIR_LEFT, 0);
      add_row(6'd0,  CMD_ENUMERATE, 32'hFFFFFFF1, 16'h0000, 1'b0, '0, 0, 0, DIR_LEFT, 0);
      add_row(6'd0,  CMD_PICK,      32'h0000000F, 16'h1234, 1'b1, 32'h0000000F, 0, 0, DIR_NONE, 1);
      add_row(6'd63, CMD_ENUMERATE, 32'h00000100, 16'h0000, 1'b0, '0, 0, 0, DIR_LEFT, 0);
      add_row(6'd5,  CMD_ENUMERATE, 32'hFFFFFFE1, 16'h0000, 1'b0, '0, 0, 0, DIR_LEFT, 0);
      add_row(6'd5,  CMD_PICK,      32'hFFFFFFE1, 16'h7FFF, 1'b0, '0, 0, 0, DIR_LEFT, 0);
      add_row(6'd4,  CMD_ENUMERATE, 32'hF0000005, 16'h0000, 1'b1, 32'hF0000005, 0, 0, DIR_NONE, 1);
      add_row(6'd32, CMD_PICK,      32'h12345678, 16'hFFFF, 1'b0, '0, 0, 0, DIR_LEFT, 0);
      add_row(6'd32, CMD_ENUMERATE, 32'hFFFF0000, 16'h0000, 1'b0, '0, 0, 0, DIR_LEFT, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < directed_rows.size(); k++) begin
         if (directed_rows[k].ring != ring_setting) write_ring(directed_rows[k].ring);
         send_request(directed_rows[k].req, directed_rows[k].known, directed_rows[k].typed);
      end

      for (s = 0; s < RANDOM_SETS; s++) begin
         write_ring((s < 7) ? ring_plan[s] : RING_W'($urandom_range(0, 63)));
         for (k = 0; k < ITEMS_PER_SET; k++) begin
            send_request(random_request(), 1'b0, '0);
         end
      end

      push <= 1'b0;
      while (pending_hops.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
